### design/rsea_pkg.sv
package rsea_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SLOTS_DEF      = 8;
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Fixed field widths
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned SIDE_W      = 2;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned FULL_DATA_W = 64;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned STAMP_W     = 32;

  // Request tdata layout, lowest bit first
  localparam int unsigned IN_SLOT_LSB = 0;
  localparam int unsigned IN_SIDE_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_MODE_LSB = IN_SIDE_LSB + SIDE_W;
  localparam int unsigned IN_DATA_LSB = IN_MODE_LSB + MODE_W;
  localparam int unsigned IN_MASK_LSB = IN_DATA_LSB + FULL_DATA_W;
  localparam int unsigned IN_TDATA_W  = ((IN_MASK_LSB + MASK_W + 7) / 8) * 8;

  // Result tdata layout
  localparam int unsigned OUT_TDATA_W = ((MODE_W + FULL_DATA_W + 7) / 8) * 8;

  // Command codes
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  // Side codes
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_BOTH  = 2'd2;

  // Result side codes
  localparam logic OUT_LEFT  = 1'b0;
  localparam logic OUT_RIGHT = 1'b1;

  localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT_L,
    ST_EMIT_R
  } state_e;

  // Only the first eight slots have a bit in the alive mask
  function automatic logic alive_at(logic [MASK_W-1:0] mask, logic [SLOT_W-1:0] idx);
    return !idx[SLOT_W-1] && mask[idx[SLOT_W-2:0]];
  endfunction

endpackage

### design/recency_slot_effect_arbiter_top.sv
// Sequence: a request is taken in the idle state, then passes through the
// store state, the scan and a wait state before each changed result is loaded,
// left side first. A new request is taken only in the idle state, and the scan
// reads one slot entry of each side memory per cycle.
// Reset: asynchronous, active low; counter, alive bits, last results and
// entry valid bits clear at once, so no clearing pass is needed.
module recency_slot_effect_arbiter_top #(
  parameter int unsigned SLOTS      = rsea_pkg::SLOTS_DEF,
  parameter int unsigned DATA_WIDTH = rsea_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // slot[3:0], side[5:4], mode[8:6], effect_data[72:9], alive_mask[80:73]
  input  logic [rsea_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // command[0]
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_mode[2:0], out_data[66:3]
  output logic [rsea_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // out_side[0]
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  localparam int unsigned SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MW      = rsea_pkg::MODE_W;
  localparam int unsigned TW      = rsea_pkg::STAMP_W;
  localparam int unsigned EW      = TW + DATA_WIDTH + MW;
  localparam int unsigned STAMP_LSB = DATA_WIDTH + MW;

  rsea_pkg::state_e state_q, state_d;

  // Request holding registers
  logic                           st_en_q, st_en_d;
  logic [SW-1:0]                  slot_q;
  logic [rsea_pkg::SIDE_W-1:0]    side_q;
  logic [MW-1:0]                  mode_q;
  logic [DATA_WIDTH-1:0]          data_q;
  logic [rsea_pkg::MASK_W-1:0]    nalive_q;
  logic                           ld_in;

  logic [TW-1:0]                  cnt_q, cnt_d;
  logic [rsea_pkg::MASK_W-1:0]    alive_q, alive_d;

  // Scan control and read stage
  logic [SW-1:0]                  rd_idx_q, rd_idx_d;
  logic                           rv_q, rv_d;
  logic [SW-1:0]                  ridx_q, ridx_d;

  // Side memories and their valid bits
  logic [EW-1:0]                  mem_q [2][SLOTS];
  logic [1:0][EW-1:0]             rdata_q;
  logic [1:0]                     rvld_q;
  logic [1:0][SLOTS-1:0]          vld_q, vld_d;
  logic [1:0]                     we;
  logic [SW-1:0]                  waddr;
  logic [1:0][EW-1:0]             wdata;

  logic [1:0][MW-1:0]             eff_mode;
  logic [1:0][DATA_WIDTH-1:0]     eff_data;
  logic [1:0][TW-1:0]             eff_stamp;

  // Running winners and last sent results
  logic [1:0][TW-1:0]             best_q, best_d;
  logic [1:0][MW-1:0]             win_mode_q, win_mode_d;
  logic [1:0][DATA_WIDTH-1:0]     win_data_q, win_data_d;
  logic [1:0][MW-1:0]             last_mode_q, last_mode_d;
  logic [1:0][DATA_WIDTH-1:0]     last_data_q, last_data_d;
  logic [1:0]                     diff;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic                           out_ld;
  logic                           out_side_q, out_side_d;
  logic [MW-1:0]                  out_mode_q, out_mode_d;
  logic [DATA_WIDTH-1:0]          out_data_q, out_data_d;
  logic                           out_tlast_q, out_tlast_d;
  logic                           out_free;
  logic                           kill;
  logic                           in_slot_ok;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      eff_mode[s]  = rvld_q[s] ? rdata_q[s][MW-1:0] : '0;
      eff_data[s]  = rvld_q[s] ? rdata_q[s][STAMP_LSB-1:MW] : '0;
      eff_stamp[s] = rvld_q[s] ? rdata_q[s][EW-1:STAMP_LSB] : '0;
      diff[s]      = (win_mode_q[s] != last_mode_q[s]) || (win_data_q[s] != last_data_q[s]);
    end
  end

  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign kill       = rsea_pkg::alive_at(alive_q, rsea_pkg::SLOT_W'(ridx_q)) &&
                      !rsea_pkg::alive_at(nalive_q, rsea_pkg::SLOT_W'(ridx_q));
  assign in_slot_ok = ({1'b0, s_axis_tdata_i[rsea_pkg::IN_SLOT_LSB +: rsea_pkg::SLOT_W]}
                       < (rsea_pkg::SLOT_W + 1)'(SLOTS));

  always_comb begin
    state_d     = state_q;
    st_en_d     = st_en_q;
    ld_in       = 1'b0;
    cnt_d       = cnt_q;
    alive_d     = alive_q;
    rd_idx_d    = rd_idx_q;
    rv_d        = 1'b0;
    ridx_d      = rd_idx_q;
    vld_d       = vld_q;
    we          = '0;
    waddr       = ridx_q;
    wdata       = '0;
    best_d      = best_q;
    win_mode_d  = win_mode_q;
    win_data_d  = win_data_q;
    last_mode_d = last_mode_q;
    last_data_d = last_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_ld      = 1'b0;
    out_side_d  = out_side_q;
    out_mode_d  = out_mode_q;
    out_data_d  = out_data_q;
    out_tlast_d = out_tlast_q;
    s_axis_tready_o = (state_q == rsea_pkg::ST_IDLE);

    // Compare stage: newest live entry wins, lowest slot on a tie
    if (rv_q) begin
      for (int s = 0; s < 2; s++) begin
        if (rsea_pkg::alive_at(nalive_q, rsea_pkg::SLOT_W'(ridx_q)) &&
            eff_mode[s] != rsea_pkg::MODE_OFF && eff_stamp[s] > best_q[s]) begin
          best_d[s]     = eff_stamp[s];
          win_mode_d[s] = eff_mode[s];
          win_data_d[s] = eff_data[s];
        end
      end
      // Turn off a slot that has just died, keep its data word
      if (kill) begin
        we    = 2'b11;
        waddr = ridx_q;
        for (int s = 0; s < 2; s++) begin
          wdata[s] = {TW'(0), eff_data[s], rsea_pkg::MODE_OFF};
        end
      end
    end

    case (state_q)
      rsea_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          ld_in   = 1'b1;
          st_en_d = (s_axis_tuser_i == rsea_pkg::CMD_STORE) && in_slot_ok;
          if (st_en_d && cnt_q != '1) begin
            cnt_d = cnt_q + 1'b1;
          end
          best_d     = '0;
          win_mode_d = '0;
          win_data_d = '0;
          state_d    = rsea_pkg::ST_STORE;
        end
      end
      rsea_pkg::ST_STORE: begin
        if (st_en_q) begin
          waddr = slot_q;
          we[0] = (side_q == rsea_pkg::SIDE_LEFT) || (side_q == rsea_pkg::SIDE_BOTH);
          we[1] = (side_q == rsea_pkg::SIDE_RIGHT) || (side_q == rsea_pkg::SIDE_BOTH);
          for (int s = 0; s < 2; s++) begin
            wdata[s] = {cnt_q, data_q, mode_q};
          end
        end
        rd_idx_d = '0;
        state_d  = rsea_pkg::ST_SCAN;
      end
      rsea_pkg::ST_SCAN: begin
        rv_d   = 1'b1;
        ridx_d = rd_idx_q;
        if (rd_idx_q == SW'(SLOTS - 1)) begin
          state_d = rsea_pkg::ST_WAIT;
        end else begin
          rd_idx_d = SW'(rd_idx_q + 1'b1);
        end
      end
      rsea_pkg::ST_WAIT: begin
        alive_d = nalive_q;
        state_d = rsea_pkg::ST_EMIT_L;
      end
      rsea_pkg::ST_EMIT_L: begin
        if (!diff[0]) begin
          state_d = rsea_pkg::ST_EMIT_R;
        end else if (out_free) begin
          out_ld         = 1'b1;
          out_valid_d    = 1'b1;
          out_side_d     = rsea_pkg::OUT_LEFT;
          out_mode_d     = win_mode_q[0];
          out_data_d     = win_data_q[0];
          out_tlast_d    = !diff[1];
          last_mode_d[0] = win_mode_q[0];
          last_data_d[0] = win_data_q[0];
          state_d        = rsea_pkg::ST_EMIT_R;
        end
      end
      rsea_pkg::ST_EMIT_R: begin
        if (!diff[1]) begin
          state_d = rsea_pkg::ST_IDLE;
        end else if (out_free) begin
          out_ld         = 1'b1;
          out_valid_d    = 1'b1;
          out_side_d     = rsea_pkg::OUT_RIGHT;
          out_mode_d     = win_mode_q[1];
          out_data_d     = win_data_q[1];
          out_tlast_d    = 1'b1;
          last_mode_d[1] = win_mode_q[1];
          last_data_d[1] = win_data_q[1];
          state_d        = rsea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsea_pkg::ST_IDLE;
      end
    endcase

    for (int s = 0; s < 2; s++) begin
      if (we[s]) begin
        vld_d[s][waddr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsea_pkg::ST_IDLE;
      st_en_q     <= 1'b0;
      cnt_q       <= '0;
      alive_q     <= '0;
      rd_idx_q    <= '0;
      rv_q        <= 1'b0;
      ridx_q      <= '0;
      vld_q       <= '0;
      rvld_q      <= '0;
      best_q      <= '0;
      win_mode_q  <= '0;
      win_data_q  <= '0;
      last_mode_q <= '0;
      last_data_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_en_q     <= st_en_d;
      cnt_q       <= cnt_d;
      alive_q     <= alive_d;
      rd_idx_q    <= rd_idx_d;
      rv_q        <= rv_d;
      ridx_q      <= ridx_d;
      vld_q       <= vld_d;
      best_q      <= best_d;
      win_mode_q  <= win_mode_d;
      win_data_q  <= win_data_d;
      last_mode_q <= last_mode_d;
      last_data_q <= last_data_d;
      out_valid_q <= out_valid_d;
      for (int s = 0; s < 2; s++) begin
        rvld_q[s] <= vld_q[s][rd_idx_q];
      end
    end
  end

  // Side memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      if (we[s]) begin
        mem_q[s][waddr] <= wdata[s];
      end
      rdata_q[s] <= mem_q[s][rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      slot_q   <= s_axis_tdata_i[rsea_pkg::IN_SLOT_LSB +: SW];
      side_q   <= s_axis_tdata_i[rsea_pkg::IN_SIDE_LSB +: rsea_pkg::SIDE_W];
      mode_q   <= s_axis_tdata_i[rsea_pkg::IN_MODE_LSB +: MW];
      data_q   <= s_axis_tdata_i[rsea_pkg::IN_DATA_LSB +: DATA_WIDTH];
      nalive_q <= s_axis_tdata_i[rsea_pkg::IN_MASK_LSB +: rsea_pkg::MASK_W];
    end
    if (out_ld) begin
      out_side_q  <= out_side_d;
      out_mode_q  <= out_mode_d;
      out_data_q  <= out_data_d;
      out_tlast_q <= out_tlast_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_side_q;
  assign m_axis_tlast_o  = out_tlast_q;
  assign m_axis_tdata_o  = rsea_pkg::OUT_TDATA_W'({rsea_pkg::FULL_DATA_W'(out_data_q),
                                                   out_mode_q});

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsea_pkg::ST_IDLE) |-> (we == 2'b00))
    else $error("memory write while idle");

  a_read_stage_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == rsea_pkg::ST_SCAN || state_q == rsea_pkg::ST_WAIT))
    else $error("read data outside the scan");

  a_counter_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q >= $past(cnt_q)))
    else $error("stamp counter went backwards");

  a_right_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == rsea_pkg::OUT_RIGHT) |-> m_axis_tlast_o)
    else $error("right result not marked final");

endmodule

### test/tb_top.sv
module tb_top;

  localparam int unsigned SLOTS = rsea_pkg::SLOTS_DEF;
  // Side code with no store target: bumps the counter only
  localparam logic [rsea_pkg::SIDE_W-1:0] SIDE_NONE = 2'd3;
  localparam int unsigned IN_PAD_W =
    rsea_pkg::IN_TDATA_W - (rsea_pkg::IN_MASK_LSB + rsea_pkg::MASK_W);
  localparam int unsigned N_RANDOM = 1930;

  typedef struct packed {
    logic                             command;
    logic [rsea_pkg::SLOT_W-1:0]      slot;
    logic [rsea_pkg::SIDE_W-1:0]      side;
    logic [rsea_pkg::MODE_W-1:0]      mode;
    logic [rsea_pkg::FULL_DATA_W-1:0] data;
    logic [rsea_pkg::MASK_W-1:0]      alive;
  } effect_req_t;

  typedef struct packed {
    logic                             side;
    logic [rsea_pkg::MODE_W-1:0]      mode;
    logic [rsea_pkg::FULL_DATA_W-1:0] data;
    logic                             last;
  } trigger_update_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rsea_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tuser  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rsea_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tlast;

  recency_slot_effect_arbiter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  effect_req_t     request_q[$];
  trigger_update_t update_q[$];
  effect_req_t     in_flight;
  trigger_update_t want;
  int              n_taken = 0;
  int              n_errors = 0;

  // Mirror of the slot table
  logic [rsea_pkg::MODE_W-1:0]      eff_mode  [SLOTS][2];
  logic [rsea_pkg::FULL_DATA_W-1:0] eff_data  [SLOTS][2];
  logic [rsea_pkg::STAMP_W-1:0]     eff_stamp [SLOTS][2];
  logic [rsea_pkg::MASK_W-1:0]      alive_now;
  logic [rsea_pkg::STAMP_W-1:0]     seq_ctr;
  logic [rsea_pkg::MODE_W-1:0]      sent_mode [2];
  logic [rsea_pkg::FULL_DATA_W-1:0] sent_data [2];

  function automatic bit is_live(logic [rsea_pkg::MASK_W-1:0] mask, int idx);
    return idx < rsea_pkg::MASK_W && mask[idx];
  endfunction

  function automatic void resolve_request(effect_req_t r);
    logic [rsea_pkg::MODE_W-1:0]      win_mode [2];
    logic [rsea_pkg::FULL_DATA_W-1:0] win_data [2];
    logic [rsea_pkg::STAMP_W-1:0]     best [2];
    trigger_update_t                  ups[$];
    trigger_update_t                  u;
    if (r.command == rsea_pkg::CMD_STORE && r.slot < SLOTS) begin
      if (seq_ctr != '1) seq_ctr++;
      for (int sd = 0; sd < 2; sd++) begin
        if (r.side == rsea_pkg::SIDE_BOTH || (sd == 0 && r.side == rsea_pkg::SIDE_LEFT) ||
            (sd == 1 && r.side == rsea_pkg::SIDE_RIGHT)) begin
          eff_mode[r.slot][sd]  = r.mode;
          eff_data[r.slot][sd]  = r.data;
          eff_stamp[r.slot][sd] = seq_ctr;
        end
      end
    end
    // Turn off both sides of slots that just died; keep their data words
    for (int i = 0; i < SLOTS; i++) begin
      if (is_live(alive_now, i) && !is_live(r.alive, i)) begin
        eff_mode[i][0]  = rsea_pkg::MODE_OFF;
        eff_mode[i][1]  = rsea_pkg::MODE_OFF;
        eff_stamp[i][0] = '0;
        eff_stamp[i][1] = '0;
      end
    end
    alive_now = r.alive;
    for (int sd = 0; sd < 2; sd++) begin
      win_mode[sd] = rsea_pkg::MODE_OFF;
      win_data[sd] = '0;
      best[sd]     = '0;
    end
    // Strict compare: the lowest slot keeps a tie
    for (int i = 0; i < SLOTS; i++) begin
      if (!is_live(alive_now, i)) continue;
      for (int sd = 0; sd < 2; sd++) begin
        if (eff_mode[i][sd] != rsea_pkg::MODE_OFF && eff_stamp[i][sd] > best[sd]) begin
          best[sd]     = eff_stamp[i][sd];
          win_mode[sd] = eff_mode[i][sd];
          win_data[sd] = eff_data[i][sd];
        end
      end
    end
    for (int sd = 0; sd < 2; sd++) begin
      if (win_mode[sd] != sent_mode[sd] || win_data[sd] != sent_data[sd]) begin
        u.side = (sd == 0) ? rsea_pkg::OUT_LEFT : rsea_pkg::OUT_RIGHT;
        u.mode = win_mode[sd];
        u.data = win_data[sd];
        u.last = 1'b0;
        ups.push_back(u);
        sent_mode[sd] = win_mode[sd];
        sent_data[sd] = win_data[sd];
      end
    end
    if (ups.size() != 0) ups[ups.size()-1].last = 1'b1;
    foreach (ups[k]) update_q.push_back(ups[k]);
  endfunction

  function automatic void add_request(logic cmd, logic [rsea_pkg::SLOT_W-1:0] slot,
                                      logic [rsea_pkg::SIDE_W-1:0] side,
                                      logic [rsea_pkg::MODE_W-1:0] mode,
                                      logic [rsea_pkg::FULL_DATA_W-1:0] data,
                                      logic [rsea_pkg::MASK_W-1:0] alive);
    effect_req_t r;
    r.command = cmd;
    r.slot    = slot;
    r.side    = side;
    r.mode    = mode;
    r.data    = data;
    r.alive   = alive;
    request_q.push_back(r);
  endfunction

  function automatic bit quiet_stretch();
    return n_taken >= 700 && n_taken < 1000;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        resolve_request(in_flight);
        n_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 34)) begin
          in_flight = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{IN_PAD_W{1'b0}}, in_flight.alive, in_flight.data,
                            in_flight.mode, in_flight.side, in_flight.slot};
          s_axis_tuser  <= in_flight.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_stretch() || ($urandom_range(99) >= 34);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (update_q.size() == 0) begin
        $error("unexpected result: side %0d mode %0d data %h", m_axis_tuser,
               m_axis_tdata[rsea_pkg::MODE_W-1:0],
               m_axis_tdata[rsea_pkg::MODE_W +: rsea_pkg::FULL_DATA_W]);
        n_errors++;
      end else begin
        want = update_q.pop_front();
        if (m_axis_tuser !== want.side) begin
          $error("out_side: expected %0d, got %0d", want.side, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[rsea_pkg::MODE_W-1:0] !== want.mode) begin
          $error("out_mode: expected %0d, got %0d", want.mode,
                 m_axis_tdata[rsea_pkg::MODE_W-1:0]);
          n_errors++;
        end
        if (m_axis_tdata[rsea_pkg::MODE_W +: rsea_pkg::FULL_DATA_W] !== want.data) begin
          $error("out_data: expected %h, got %h", want.data,
                 m_axis_tdata[rsea_pkg::MODE_W +: rsea_pkg::FULL_DATA_W]);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [rsea_pkg::MASK_W-1:0] roster;
    logic [rsea_pkg::FULL_DATA_W-1:0] word;
    for (int i = 0; i < SLOTS; i++) begin
      for (int sd = 0; sd < 2; sd++) begin
        eff_mode[i][sd]  = rsea_pkg::MODE_OFF;
        eff_data[i][sd]  = '0;
        eff_stamp[i][sd] = '0;
      end
    end
    alive_now = '0;
    seq_ctr   = '0;
    for (int sd = 0; sd < 2; sd++) begin
      sent_mode[sd] = rsea_pkg::MODE_OFF;
      sent_data[sd] = '0;
    end

    // Nothing stored yet, all dead then all alive
    add_request(rsea_pkg::CMD_REFRESH, 4'd0, rsea_pkg::SIDE_LEFT, rsea_pkg::MODE_OFF, '0,
                8'h00);
    add_request(rsea_pkg::CMD_REFRESH, 4'd0, rsea_pkg::SIDE_LEFT, rsea_pkg::MODE_OFF, '0,
                8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd0, rsea_pkg::SIDE_LEFT, 3'd5, '1, 8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd1, rsea_pkg::SIDE_RIGHT, 3'd7, '0, 8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd2, rsea_pkg::SIDE_BOTH, 3'd1,
                64'hA5A5_5A5A_F00F_0FF0, 8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd7, rsea_pkg::SIDE_BOTH, 3'd3,
                64'h0123_4567_89AB_CDEF, 8'hFF);
    // Out-of-range slots: store dropped, counter held
    add_request(rsea_pkg::CMD_STORE, 4'd8, rsea_pkg::SIDE_BOTH, 3'd6,
                64'hDEAD_BEEF_0000_0001, 8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd15, rsea_pkg::SIDE_LEFT, 3'd2, '1, 8'hFF);
    // No side written, counter still bumps
    add_request(rsea_pkg::CMD_STORE, 4'd3, SIDE_NONE, 3'd6, 64'h5555_AAAA_5555_AAAA, 8'hFF);
    // Mode zero stored counts as off
    add_request(rsea_pkg::CMD_STORE, 4'd7, rsea_pkg::SIDE_LEFT, rsea_pkg::MODE_OFF,
                64'h1111_2222_3333_4444, 8'hFF);
    add_request(rsea_pkg::CMD_REFRESH, 4'd7, rsea_pkg::SIDE_BOTH, 3'd7, '1, 8'h7F);
    add_request(rsea_pkg::CMD_REFRESH, 4'd0, rsea_pkg::SIDE_LEFT, rsea_pkg::MODE_OFF, '0,
                8'h00);
    // Revived slots stay off
    add_request(rsea_pkg::CMD_REFRESH, 4'd0, rsea_pkg::SIDE_LEFT, rsea_pkg::MODE_OFF, '0,
                8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd4, rsea_pkg::SIDE_BOTH, 3'd2,
                64'h8000_0000_0000_0000, 8'hFF);
    add_request(rsea_pkg::CMD_REFRESH, 4'd4, rsea_pkg::SIDE_BOTH, 3'd2, '0, 8'hEF);
    add_request(rsea_pkg::CMD_REFRESH, 4'd4, rsea_pkg::SIDE_BOTH, 3'd2, '0, 8'hFF);
    add_request(rsea_pkg::CMD_STORE, 4'd5, rsea_pkg::SIDE_LEFT, 3'd4, 64'd1, 8'h20);
    add_request(rsea_pkg::CMD_STORE, 4'd6, rsea_pkg::SIDE_RIGHT, 3'd7,
                64'h8000_0000_0000_0000, 8'h60);
    add_request(rsea_pkg::CMD_STORE, 4'd0, rsea_pkg::SIDE_BOTH, 3'd7, '1, 8'h61);
    add_request(rsea_pkg::CMD_STORE, 4'd3, rsea_pkg::SIDE_LEFT, 3'd1, '0, 8'h69);
    add_request(rsea_pkg::CMD_REFRESH, 4'd0, rsea_pkg::SIDE_LEFT, rsea_pkg::MODE_OFF, '0,
                8'h68);

    roster = 8'hFF;
    repeat (N_RANDOM) begin
      word = {$urandom, $urandom};
      if ($urandom_range(3) == 0) word = rsea_pkg::FULL_DATA_W'($urandom_range(15));
      if ($urandom_range(99) < 85) begin
        // Mostly stable clients with the odd one joining or leaving
        if ($urandom_range(9) == 0) begin
          roster ^= rsea_pkg::MASK_W'(1 << $urandom_range(rsea_pkg::MASK_W-1));
        end
        add_request(($urandom_range(3) == 0) ? rsea_pkg::CMD_REFRESH : rsea_pkg::CMD_STORE,
                    ($urandom_range(9) == 0) ? rsea_pkg::SLOT_W'($urandom_range(15))
                                             : rsea_pkg::SLOT_W'($urandom_range(SLOTS-1)),
                    ($urandom_range(19) == 0) ? SIDE_NONE
                                              : rsea_pkg::SIDE_W'($urandom_range(2)),
                    ($urandom_range(7) == 0) ? rsea_pkg::MODE_OFF
                                             : rsea_pkg::MODE_W'($urandom_range(7, 1)),
                    word, roster);
      end else begin
        add_request(1'($urandom_range(1)), rsea_pkg::SLOT_W'($urandom_range(15)),
                    rsea_pkg::SIDE_W'($urandom_range(3)),
                    rsea_pkg::MODE_W'($urandom_range(7)), word,
                    rsea_pkg::MASK_W'($urandom_range(255)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (update_q.size() != 0) @(posedge clk_i);
    repeat (4 * (SLOTS + 5)) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
design/rsea_pkg.sv
design/recency_slot_effect_arbiter_top.sv
test/tb_top.sv
